[hdl/xsde_pkg.sv]
// ----------------------------------------------------------------------------
// xsde_pkg
// Shared types, sizes and codes of the XOR sprite display engine.
// ----------------------------------------------------------------------------
package xsde_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int COL_W         = $clog2(SCREEN_WIDTH);
	localparam int LINE_W        = $clog2(SCREEN_HEIGHT);
	localparam int ROW_PIXELS    = 16;

	localparam logic [3:0] CMD_CLEAR  = 4'd0;
	localparam logic [3:0] CMD_DRAW8  = 4'd1;
	localparam logic [3:0] CMD_DRAW16 = 4'd2;
	localparam logic [3:0] CMD_DOWN   = 4'd3;
	localparam logic [3:0] CMD_UP     = 4'd4;
	localparam logic [3:0] CMD_LEFT   = 4'd5;
	localparam logic [3:0] CMD_RIGHT  = 4'd6;
	localparam logic [3:0] CMD_LORES  = 4'd7;
	localparam logic [3:0] CMD_HIRES  = 4'd8;

	typedef logic [SCREEN_WIDTH-1:0] line_t;
	typedef logic [LINE_W-1:0]       line_addr_t;
	typedef logic [2:0]              lop_t;

	localparam lop_t LOP_ZERO  = 3'd0;
	localparam lop_t LOP_COPY  = 3'd1;
	localparam lop_t LOP_SHL   = 3'd2;
	localparam lop_t LOP_SHR   = 3'd3;
	localparam lop_t LOP_MERGE = 3'd4;

	typedef struct packed {
		lop_t       op;
		logic [3:0] amt;
	} lu_ctrl_t;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [3:0]  row_index;
		logic [15:0] row_bits;
		logic [3:0]  amount;
	} req_t;

	typedef struct packed {
		logic collision;
		logic high_res;
	} rsp_t;

endpackage

[hdl/xsde_frame_mem.sv]
// ----------------------------------------------------------------------------
// xsde_frame_mem
// Frame line store, one write and one registered read per cycle; per-line
// valid bits make unwritten or cleared lines read as blank.
// ----------------------------------------------------------------------------
module xsde_frame_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear_all,
	input  xsde_pkg::line_addr_t rd_addr,
	output xsde_pkg::line_t     rd_line,
	input  logic                wr_en,
	input  xsde_pkg::line_addr_t wr_addr,
	input  xsde_pkg::line_t     wr_data
);
	import xsde_pkg::*;

	line_t                   mem [SCREEN_HEIGHT];
	logic [SCREEN_HEIGHT-1:0] vld_q;
	line_t                   rd_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (clear_all) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_line = rd_vld_q ? rd_q : '0;

endmodule

[hdl/xsde_row_mask.sv]
// ----------------------------------------------------------------------------
// xsde_row_mask
// Map one sprite row onto a frame line: columns touched, their new values
// and whether any touched block was lit.
// ----------------------------------------------------------------------------
module xsde_row_mask (
	input  xsde_pkg::line_t line,
	input  logic [7:0]      pos_x,
	input  logic [15:0]     bits,
	input  logic            hires,
	output xsde_pkg::line_t mask,
	output xsde_pkg::line_t nvv,
	output logic            hit
);
	import xsde_pkg::*;

	logic [COL_W-1:0] col  [ROW_PIXELS];
	logic [COL_W-1:0] col1 [ROW_PIXELS];

	always_comb begin
		logic [8:0] lx;
		for (int k = 0; k < ROW_PIXELS; k++) begin
			lx      = {1'b0, pos_x} + 9'(k);
			col[k]  = hires ? COL_W'(lx) : COL_W'({lx, 1'b0});
			col1[k] = col[k] + 1'b1;
		end
	end

	always_comb begin
		mask = '0;
		nvv  = '0;
		hit  = 1'b0;
		for (int k = 0; k < ROW_PIXELS; k++) begin
			if (bits[ROW_PIXELS-1-k]) begin
				mask[col[k]] = 1'b1;
				nvv[col[k]]  = ~line[col[k]];
				hit          = hit | line[col[k]];
				if (!hires) begin
					mask[col1[k]] = 1'b1;
					nvv[col1[k]]  = ~line[col[k]];
				end
			end
		end
	end

endmodule

[hdl/xsde_line_unit.sv]
// ----------------------------------------------------------------------------
// xsde_line_unit
// Shared line datapath: zero, copy, shift or masked merge of one frame line.
// ----------------------------------------------------------------------------
module xsde_line_unit (
	input  xsde_pkg::lu_ctrl_t ctrl,
	input  xsde_pkg::line_t    line,
	input  xsde_pkg::line_t    mask,
	input  xsde_pkg::line_t    nvv,
	output xsde_pkg::line_t    result
);
	import xsde_pkg::*;

	always_comb begin
		case (ctrl.op)
			LOP_ZERO:  result = '0;
			LOP_COPY:  result = line;
			LOP_SHL:   result = line << ctrl.amt;
			LOP_SHR:   result = line >> ctrl.amt;
			LOP_MERGE: result = (line & ~mask) | (nvv & mask);
			default:   result = line;
		endcase
	end

endmodule

[hdl/xor_sprite_display_engine.sv]
// ----------------------------------------------------------------------------
// xor_sprite_display_engine
// Clear, mode and unused commands go from accept straight to the result
// beat; a draw row does one line read-modify-write through the frame memory
// port in high resolution and two in low resolution; a scroll does one read
// and one write per line over every line, or none for a scroll by zero.
// One command at a time: the next command is accepted no earlier than the
// result beat.
// Reset: blank frame, low resolution, collision clear; no clearing pass.
// ----------------------------------------------------------------------------
module xor_sprite_display_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  xsde_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output xsde_pkg::rsp_t  rsp_data
);
	import xsde_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_WR   = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]  state_q;
	logic [3:0]  cmd_q;
	logic [7:0]  px_q;
	logic [15:0] bits_q;
	logic [3:0]  amt_q;
	logic        row0_q;
	line_addr_t  y0_q;
	line_addr_t  y1_q;
	logic        step_q;
	line_addr_t  line_q;
	line_addr_t  wr_addr_q;
	logic        zsrc_q;
	line_t       mask_q;
	line_t       nvv_q;
	logic        hires_q;
	logic        coll_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic        accept;
	logic        clear_all;
	logic        is_draw;
	logic [8:0]  ysum;
	line_addr_t  y0_next;
	line_addr_t  dst;
	logic [LINE_W:0] src_wide;
	logic        src_ok;
	line_addr_t  rd_addr;
	line_t       rd_line;
	line_t       rm_mask;
	line_t       rm_nvv;
	logic        rm_hit;
	lu_ctrl_t    lu_ctrl;
	line_t       lu_mask;
	line_t       lu_nvv;
	line_t       lu_result;
	logic        wr_en;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign clear_all = accept && (req_data.cmd == CMD_CLEAR);
	assign is_draw   = (cmd_q == CMD_DRAW8) || (cmd_q == CMD_DRAW16);

	assign ysum    = {1'b0, req_data.pos_y} + {5'd0, req_data.row_index};
	assign y0_next = hires_q ? LINE_W'(ysum) : LINE_W'({ysum, 1'b0});

	always_comb begin
		if (cmd_q == CMD_DOWN) begin
			dst      = line_addr_t'(SCREEN_HEIGHT - 1) - line_q;
			src_ok   = ({1'b0, dst} >= (LINE_W + 1)'(amt_q));
			src_wide = {1'b0, dst} - (LINE_W + 1)'(amt_q);
		end else if (cmd_q == CMD_UP) begin
			dst      = line_q;
			src_wide = {1'b0, dst} + (LINE_W + 1)'(amt_q);
			src_ok   = (src_wide < (LINE_W + 1)'(SCREEN_HEIGHT));
		end else begin
			dst      = line_q;
			src_wide = {1'b0, line_q};
			src_ok   = 1'b1;
		end
	end

	always_comb begin
		if (is_draw) begin
			rd_addr = step_q ? y1_q : y0_q;
		end else begin
			rd_addr = LINE_W'(src_wide);
		end
	end

	assign wr_en = (state_q == ST_WR);

	xsde_frame_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear_all (clear_all),
		.rd_addr   (rd_addr),
		.rd_line   (rd_line),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr_q),
		.wr_data   (lu_result)
	);

	xsde_row_mask u_mask (
		.line  (rd_line),
		.pos_x (px_q),
		.bits  (bits_q),
		.hires (hires_q),
		.mask  (rm_mask),
		.nvv   (rm_nvv),
		.hit   (rm_hit)
	);

	always_comb begin
		lu_ctrl.amt = amt_q;
		if (is_draw) begin
			lu_ctrl.op = LOP_MERGE;
		end else if (zsrc_q) begin
			lu_ctrl.op = LOP_ZERO;
		end else if (cmd_q == CMD_LEFT) begin
			lu_ctrl.op = LOP_SHR;
		end else if (cmd_q == CMD_RIGHT) begin
			lu_ctrl.op = LOP_SHL;
		end else begin
			lu_ctrl.op = LOP_COPY;
		end
	end

	assign lu_mask = step_q ? mask_q : rm_mask;
	assign lu_nvv  = step_q ? nvv_q : rm_nvv;

	xsde_line_unit u_line (
		.ctrl   (lu_ctrl),
		.line   (rd_line),
		.mask   (lu_mask),
		.nvv    (lu_nvv),
		.result (lu_result)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req_data.cmd;
			px_q   <= req_data.pos_x;
			amt_q  <= req_data.amount;
			row0_q <= (req_data.row_index == 4'd0);
			y0_q   <= y0_next;
			y1_q   <= y0_next + 1'b1;
			bits_q <= (req_data.cmd == CMD_DRAW8) ? {req_data.row_bits[7:0], 8'h00}
				: req_data.row_bits;
		end
		if (state_q == ST_RD) begin
			wr_addr_q <= is_draw ? rd_addr : dst;
			zsrc_q    <= !src_ok;
		end
		if ((state_q == ST_WR) && is_draw && !step_q) begin
			mask_q <= rm_mask;
			nvv_q  <= rm_nvv;
		end
		if ((state_q == ST_DONE) && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.collision <= coll_q;
			rsp_q.high_res  <= hires_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 1'b0;
			line_q      <= '0;
			hires_q     <= 1'b0;
			coll_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= 1'b0;
						line_q <= '0;
						case (req_data.cmd)
							CMD_DRAW8, CMD_DRAW16: state_q <= ST_RD;
							CMD_DOWN, CMD_UP, CMD_LEFT, CMD_RIGHT: begin
								state_q <= (req_data.amount == 4'd0) ? ST_DONE : ST_RD;
							end
							CMD_LORES: begin
								hires_q <= 1'b0;
								state_q <= ST_DONE;
							end
							CMD_HIRES: begin
								hires_q <= 1'b1;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					if (is_draw) begin
						if (!step_q) begin
							coll_q <= (coll_q & !row0_q) | rm_hit;
						end
						if (!step_q && !hires_q) begin
							step_q  <= 1'b1;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (line_q == line_addr_t'(SCREEN_HEIGHT - 1)) begin
						state_q <= ST_DONE;
					end else begin
						line_q  <= line_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XOR sprite display engine. A short table of
// commands covers every opcode, coordinate wrap, both resolutions, collision
// set and clear, and scrolls by zero and by the largest amount. Random sprite
// sequences, scrolls, mode switches and noise follow. Each status beat is
// checked field by field against a table status or an in-bench frame model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import xsde_pkg::*;

	localparam int          HALF_PERIOD  = 6;
	localparam int          RESET_CYCLES = 5;
	localparam int          RANDOM_ITEMS = 500;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 2 * SCREEN_HEIGHT + 16;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	typedef struct {
		req_t beat;
		bit   typed;
		rsp_t status;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_data;

	line_t       frame_q [SCREEN_HEIGHT];
	logic        hires_q;
	logic        collide_q;
	rsp_t        pending_status [$];
	table_row_t  directed_rows [$];
	int          accepted_count = 0;
	int          error_count    = 0;
	int unsigned cycle_count    = 0;

	xor_sprite_display_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic bit quiet_window();
		return accepted_count >= 250 && accepted_count < 350;
	endfunction

	function automatic void draw_sprite_row(int unsigned px, int unsigned py,
			int unsigned row, logic [15:0] bits, int unsigned width);
		int unsigned x, y, x1, y1;
		logic        was;
		if (row == 0)
			collide_q = 1'b0;
		for (int unsigned k = 0; k < width; k++) begin
			if (bits[width - 1 - k]) begin
				if (hires_q) begin
					x = (px + k) % SCREEN_WIDTH;
					y = (py + row) % SCREEN_HEIGHT;
					was = frame_q[y][x];
					frame_q[y][x] = ~was;
				end else begin
					x  = (2 * (px + k)) % SCREEN_WIDTH;
					y  = (2 * (py + row)) % SCREEN_HEIGHT;
					x1 = (x + 1) % SCREEN_WIDTH;
					y1 = (y + 1) % SCREEN_HEIGHT;
					was = frame_q[y][x];
					frame_q[y][x]   = ~was;
					frame_q[y][x1]  = ~was;
					frame_q[y1][x]  = ~was;
					frame_q[y1][x1] = ~was;
				end
				if (was)
					collide_q = 1'b1;
			end
		end
	endfunction

	function automatic rsp_t apply_display_cmd(req_t b);
		int   n;
		rsp_t status;
		n = int'(b.amount);
		case (b.cmd)
			CMD_CLEAR: begin
				foreach (frame_q[i])
					frame_q[i] = '0;
			end
			CMD_DRAW8: begin
				draw_sprite_row(32'(b.pos_x), 32'(b.pos_y), 32'(b.row_index),
					{8'h00, b.row_bits[7:0]}, 8);
			end
			CMD_DRAW16: begin
				draw_sprite_row(32'(b.pos_x), 32'(b.pos_y), 32'(b.row_index),
					b.row_bits, ROW_PIXELS);
			end
			CMD_DOWN: begin
				if (n != 0) begin
					for (int y = SCREEN_HEIGHT - 1; y >= n; y--)
						frame_q[y] = frame_q[y - n];
					for (int y = 0; y < n; y++)
						frame_q[y] = '0;
				end
			end
			CMD_UP: begin
				if (n != 0) begin
					for (int y = 0; y + n < SCREEN_HEIGHT; y++)
						frame_q[y] = frame_q[y + n];
					for (int y = SCREEN_HEIGHT - n; y < SCREEN_HEIGHT; y++)
						frame_q[y] = '0;
				end
			end
			CMD_LEFT: begin
				foreach (frame_q[i])
					frame_q[i] = frame_q[i] >> n;
			end
			CMD_RIGHT: begin
				foreach (frame_q[i])
					frame_q[i] = frame_q[i] << n;
			end
			CMD_LORES: hires_q = 1'b0;
			CMD_HIRES: hires_q = 1'b1;
			default: ;
		endcase
		status.collision = collide_q;
		status.high_res  = hires_q;
		return status;
	endfunction

	function automatic void add_row(logic [3:0] cmd, logic [7:0] x, logic [7:0] y,
			logic [3:0] row, logic [15:0] bits, logic [3:0] amt,
			bit typed, logic coll, logic hr);
		table_row_t r;
		r.beat.cmd       = cmd;
		r.beat.pos_x     = x;
		r.beat.pos_y     = y;
		r.beat.row_index = row;
		r.beat.row_bits  = bits;
		r.beat.amount    = amt;
		r.typed          = typed;
		r.status.collision = coll;
		r.status.high_res  = hr;
		directed_rows.push_back(r);
	endfunction

	function automatic req_t random_beat(logic [3:0] cmd);
		req_t b;
		b.cmd       = cmd;
		b.pos_x     = 8'($urandom_range(0, 255));
		b.pos_y     = 8'($urandom_range(0, 255));
		b.row_index = 4'($urandom_range(0, 15));
		b.row_bits  = 16'($urandom_range(0, 65535));
		b.amount    = 4'($urandom_range(0, 15));
		return b;
	endfunction

	task automatic offer(input req_t beat, input bit typed, input rsp_t typed_status);
		rsp_t predicted;
		req_data  <= beat;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predicted = apply_display_cmd(beat);
		pending_status.push_back(typed ? typed_status : predicted);
		accepted_count++;
	endtask

	task automatic sender_gap();
		if (!quiet_window() && $urandom_range(0, 99) < 33) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_random(input req_t beat, inout bit paused);
		rsp_t none;
		none = '0;
		offer(beat, 1'b0, none);
		if (!paused && accepted_count >= 420) begin
			paused = 1'b1;
			req_valid <= 1'b0;
			while (pending_status.size() != 0) @(posedge clk);
		end else begin
			sender_gap();
		end
	endtask

	initial begin : status_sink
		int   hold_left;
		bit   hold_done;
		rsp_t want;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				if (pending_status.size() == 0) begin
					$error("status beat with nothing expected: collision=%0b high_res=%0b",
						rsp_data.collision, rsp_data.high_res);
					error_count++;
				end else begin
					want = pending_status.pop_front();
					if (rsp_data.collision !== want.collision) begin
						$error("collision: expected %0b, got %0b", want.collision, rsp_data.collision);
						error_count++;
					end
					if (rsp_data.high_res !== want.high_res) begin
						$error("high_res: expected %0b, got %0b", want.high_res, rsp_data.high_res);
						error_count++;
					end
				end
			end
			if (!hold_done && accepted_count >= 100) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= quiet_window() || $urandom_range(0, 99) >= 33;
			end
		end
	end

	initial begin : command_source
		int   kind;
		int   rows;
		int   random_count;
		bit   paused;
		req_t beat;
		logic [3:0] draw_cmd;

		foreach (frame_q[i])
			frame_q[i] = '0;
		hires_q   = 1'b0;
		collide_q = 1'b0;
		paused    = 1'b0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_data  <= '0;

		add_row(4'd15,      8'd0,   8'd0,   4'd0,  16'h0000, 4'd0,  1, 0, 0);
		add_row(4'd9,       8'd255, 8'd255, 4'd15, 16'hFFFF, 4'd15, 1, 0, 0);
		add_row(CMD_DRAW8,  8'd0,   8'd0,   4'd0,  16'hFFFF, 4'd0,  1, 0, 0);
		add_row(CMD_DRAW8,  8'd0,   8'd0,   4'd0,  16'h00FF, 4'd0,  1, 1, 0);
		add_row(CMD_DRAW8,  8'd0,   8'd0,   4'd1,  16'h0000, 4'd0,  1, 1, 0);
		add_row(CMD_DRAW16, 8'd255, 8'd255, 4'd0,  16'hFFFF, 4'd15, 0, 0, 0);
		add_row(CMD_DRAW16, 8'd255, 8'd255, 4'd15, 16'hFFFF, 4'd0,  0, 0, 0);
		add_row(CMD_HIRES,  8'd0,   8'd0,   4'd0,  16'h0000, 4'd0,  0, 0, 0);
		add_row(CMD_CLEAR,  8'd0,   8'd0,   4'd0,  16'h0000, 4'd0,  0, 0, 0);
		add_row(CMD_DRAW16, 8'd120, 8'd60,  4'd0,  16'hFFFF, 4'd0,  1, 0, 1);
		add_row(CMD_DRAW16, 8'd120, 8'd60,  4'd0,  16'hFFFF, 4'd0,  1, 1, 1);
		add_row(CMD_DRAW8,  8'd255, 8'd255, 4'd3,  16'h5AA5, 4'd0,  0, 0, 0);
		add_row(CMD_DOWN,   8'd0,   8'd0,   4'd0,  16'h0000, 4'd0,  0, 0, 0);
		add_row(CMD_DOWN,   8'd0,   8'd0,   4'd0,  16'h0000, 4'd15, 0, 0, 0);
		add_row(CMD_UP,     8'd0,   8'd0,   4'd0,  16'h0000, 4'd15, 0, 0, 0);
		add_row(CMD_UP,     8'd0,   8'd0,   4'd0,  16'h0000, 4'd0,  0, 0, 0);
		add_row(CMD_LEFT,   8'd0,   8'd0,   4'd0,  16'h0000, 4'd15, 0, 0, 0);
		add_row(CMD_LEFT,   8'd0,   8'd0,   4'd0,  16'h0000, 4'd1,  0, 0, 0);
		add_row(CMD_RIGHT,  8'd0,   8'd0,   4'd0,  16'h0000, 4'd15, 0, 0, 0);
		add_row(CMD_RIGHT,  8'd0,   8'd0,   4'd0,  16'h0000, 4'd0,  0, 0, 0);
		add_row(CMD_DRAW8,  8'd0,   8'd0,   4'd0,  16'h00FF, 4'd0,  0, 0, 0);
		add_row(CMD_LORES,  8'd0,   8'd0,   4'd0,  16'h0000, 4'd0,  0, 0, 0);
		add_row(CMD_CLEAR,  8'd0,   8'd0,   4'd0,  16'h0000, 4'd0,  0, 0, 0);
		add_row(CMD_DRAW16, 8'd63,  8'd31,  4'd0,  16'h8001, 4'd0,  1, 0, 0);
		add_row(4'd12,      8'd0,   8'd0,   4'd0,  16'h0000, 4'd0,  0, 0, 0);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].status);
			sender_gap();
		end

		random_count = accepted_count;
		while (accepted_count - random_count < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				draw_cmd = ($urandom_range(0, 1) != 0) ? CMD_DRAW16 : CMD_DRAW8;
				beat = random_beat(draw_cmd);
				rows = $urandom_range(1, 16);
				for (int r = 0; r < rows; r++) begin
					beat.row_index = 4'(r);
					beat.row_bits  = 16'($urandom_range(0, 65535));
					beat.amount    = 4'($urandom_range(0, 15));
					send_random(beat, paused);
				end
			end else if (kind < 70) begin
				beat = random_beat(4'($urandom_range(CMD_DOWN, CMD_RIGHT)));
				send_random(beat, paused);
			end else if (kind < 80) begin
				beat = random_beat(($urandom_range(0, 1) != 0) ? CMD_HIRES : CMD_LORES);
				send_random(beat, paused);
			end else if (kind < 85) begin
				send_random(random_beat(CMD_CLEAR), paused);
			end else if (kind < 93) begin
				send_random(random_beat(4'($urandom_range(0, 15))), paused);
			end else begin
				beat = random_beat(($urandom_range(0, 1) != 0) ? CMD_DRAW16 : CMD_DRAW8);
				rows = $urandom_range(1, 6);
				for (int r = 0; r < rows; r++) begin
					beat.row_index = 4'($urandom_range(1, 15));
					beat.row_bits  = 16'($urandom_range(0, 65535));
					send_random(beat, paused);
				end
			end
		end

		req_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
